// ===== hdl/pdf_pkg.sv =====
// ----------------------------------------------------------------------------
// pdf_pkg
// Shared types and constants of the per-ID packet decimation filter: field
// widths, verdict and register codes, controller states and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package pdf_pkg;

  // Field widths
  localparam int ID_W    = 16;
  localparam int DEC_W   = 8;
  localparam int CNT_W   = 8;
  localparam int TOTAL_W = 32;
  localparam int USE_W   = 7;
  localparam int VERD_W  = 3;

  // Configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // Default table depth
  localparam int MAX_ENTRIES_DEF = 64;

  // Request action codes
  localparam logic ACT_ADD    = 1'b0;
  localparam logic ACT_PACKET = 1'b1;

  // Register index codes (word index from paddr)
  localparam logic REG_CMD_ID  = 1'b0;
  localparam logic REG_WAKE_ID = 1'b1;

  typedef enum logic [VERD_W-1:0] {
    V_SENT    = 3'd0,
    V_DROPPED = 3'd1,
    V_NOMATCH = 3'd2,
    V_CYCLE   = 3'd3,
    V_ADDED   = 3'd4,
    V_FULL    = 3'd5
  } verdict_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN
  } ctrl_state_t;

  // One filter table entry
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [DEC_W-1:0] dec;
    logic [CNT_W-1:0] cnt;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic load;        // capture request fields
    logic scan_first;  // read entry 0
    logic scan_next;   // read next entry
    logic do_add;      // append entry or report full
    logic do_cycle;    // count command or wakeup packet
    logic do_hit;      // update matched entry and totals
    logic do_nomatch;  // report no matching filter
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_add;
    logic is_cycle;
    logic empty;
    logic more;
    logic match;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== hdl/pdf_regs.sv =====
// ----------------------------------------------------------------------------
// pdf_regs
// Configuration registers behind the APB-style port: command ID and wakeup
// ID, with zero-wait writes and read-back.
// ----------------------------------------------------------------------------
`default_nettype none

module pdf_regs (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [pdf_pkg::APB_AW-1:0] paddr,
  input  wire logic [pdf_pkg::APB_DW-1:0] pwdata,
  output logic      [pdf_pkg::APB_DW-1:0] prdata,
  output logic                            pready,
  output logic      [pdf_pkg::ID_W-1:0]   cmd_id,
  output logic      [pdf_pkg::ID_W-1:0]   wake_id
);
  import pdf_pkg::*;

  logic [ID_W-1:0] cmd_id_r;
  logic [ID_W-1:0] cmd_id_nxt;
  logic [ID_W-1:0] wake_id_r;
  logic [ID_W-1:0] wake_id_nxt;
  logic            wr_hit;
  logic            reg_sel;

  assign pready  = 1'b1;
  assign wr_hit  = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  // Decode register writes
  always_comb begin
    cmd_id_nxt  = cmd_id_r;
    wake_id_nxt = wake_id_r;
    if (wr_hit) begin
      case (reg_sel)
        REG_CMD_ID:  cmd_id_nxt  = pwdata[ID_W-1:0];
        REG_WAKE_ID: wake_id_nxt = pwdata[ID_W-1:0];
        default:     cmd_id_nxt  = cmd_id_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_id_r  <= '0;
      wake_id_r <= '0;
    end else begin
      cmd_id_r  <= cmd_id_nxt;
      wake_id_r <= wake_id_nxt;
    end
  end

  // Read back
  always_comb begin
    case (reg_sel)
      REG_CMD_ID:  prdata = {{(APB_DW-ID_W){1'b0}}, cmd_id_r};
      REG_WAKE_ID: prdata = {{(APB_DW-ID_W){1'b0}}, wake_id_r};
      default:     prdata = '0;
    endcase
  end

  assign cmd_id  = cmd_id_r;
  assign wake_id = wake_id_r;

endmodule

`default_nettype wire

// ===== hdl/pdf_ctrl.sv =====
// ----------------------------------------------------------------------------
// pdf_ctrl
// Request sequencer: takes a request, decides its kind, walks the filter
// table one entry per cycle and issues the finishing command.
// ----------------------------------------------------------------------------
`default_nettype none

module pdf_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire pdf_pkg::dp_stat_t    stat,
  output pdf_pkg::ctrl_cmd_t        cmd
);
  import pdf_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (stat.is_add) begin
          cmd.do_add = 1'b1;
          state_nxt  = ST_IDLE;
        end else if (stat.is_cycle) begin
          cmd.do_cycle = 1'b1;
          state_nxt    = ST_IDLE;
        end else if (stat.empty) begin
          cmd.do_nomatch = 1'b1;
          state_nxt      = ST_IDLE;
        end else begin
          cmd.scan_first = 1'b1;
          state_nxt      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // First match wins; otherwise keep reading until the table ends
        if (stat.match) begin
          cmd.do_hit = 1'b1;
          state_nxt  = ST_IDLE;
        end else if (stat.more) begin
          cmd.scan_next = 1'b1;
        end else begin
          cmd.do_nomatch = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/pdf_dp.sv =====
// ----------------------------------------------------------------------------
// pdf_dp
// Datapath: filter table memory with registered read, request registers,
// entry count, sent/dropped/cycle totals and the result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module pdf_dp #(
  parameter int MAX_ENTRIES = pdf_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire pdf_pkg::ctrl_cmd_t          cmd,
  output pdf_pkg::dp_stat_t                stat,
  input  wire logic                        in_action,
  input  wire logic [pdf_pkg::ID_W-1:0]    in_msg_id,
  input  wire logic [pdf_pkg::DEC_W-1:0]   in_decimation,
  input  wire logic [pdf_pkg::ID_W-1:0]    cmd_id,
  input  wire logic [pdf_pkg::ID_W-1:0]    wake_id,
  output logic                             out_strobe,
  output logic [pdf_pkg::VERD_W-1:0]       out_verdict,
  output logic [pdf_pkg::TOTAL_W-1:0]      out_sent_total,
  output logic [pdf_pkg::TOTAL_W-1:0]      out_dropped_total,
  output logic [pdf_pkg::TOTAL_W-1:0]      out_cycle_total,
  output logic [pdf_pkg::USE_W-1:0]        out_entries_in_use
);
  import pdf_pkg::*;

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  // Filter table
  entry_t entry_mem [MAX_ENTRIES];

  logic             req_action_r;
  logic [ID_W-1:0]  req_id_r;
  logic [DEC_W-1:0] req_dec_r;

  logic [CW-1:0]    count_r;
  logic [CW-1:0]    count_nxt;
  logic [CW-1:0]    scan_idx_r;
  logic [CW-1:0]    scan_idx_nxt;
  logic [IW-1:0]    chk_idx_r;
  entry_t           rd_data_r;

  logic [TOTAL_W-1:0] sent_r;
  logic [TOTAL_W-1:0] sent_nxt;
  logic [TOTAL_W-1:0] drop_r;
  logic [TOTAL_W-1:0] drop_nxt;
  logic [TOTAL_W-1:0] cyc_r;
  logic [TOTAL_W-1:0] cyc_nxt;

  logic     strobe_r;
  logic     strobe_nxt;
  verdict_t verdict_r;
  verdict_t verdict_nxt;

  logic             rd_en;
  logic [IW-1:0]    rd_addr;
  logic             wr_en;
  logic [IW-1:0]    wr_addr;
  entry_t           wr_data;
  logic             full;
  logic [CNT_W-1:0] cnt_inc;
  logic             pass;

  logic [CW+USE_W-1:0] use_ext;

  // Hold request fields
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_action_r <= in_action;
      req_id_r     <= in_msg_id;
      req_dec_r    <= in_decimation;
    end
  end

  // Status
  assign full        = (count_r == CW'(MAX_ENTRIES));
  assign stat.is_add   = (req_action_r == ACT_ADD);
  assign stat.is_cycle = (req_id_r == cmd_id) || (req_id_r == wake_id);
  assign stat.empty    = (count_r == '0);
  assign stat.more     = (scan_idx_r < count_r);
  assign stat.match    = (rd_data_r.id == req_id_r);

  // Table read: one entry per cycle
  assign rd_en   = cmd.scan_first || cmd.scan_next;
  assign rd_addr = cmd.scan_first ? '0 : scan_idx_r[IW-1:0];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= entry_mem[rd_addr];
      chk_idx_r <= rd_addr;
    end
  end

  always_comb begin
    scan_idx_nxt = scan_idx_r;
    if (cmd.scan_first) begin
      scan_idx_nxt = CW'(1);
    end else if (cmd.scan_next) begin
      scan_idx_nxt = scan_idx_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
    end else begin
      scan_idx_r <= scan_idx_nxt;
    end
  end

  // Decimation check on the matched entry
  assign cnt_inc = rd_data_r.cnt + CNT_W'(1);
  assign pass    = (cnt_inc >= rd_data_r.dec);

  // Table write: append on add, counter write-back on hit
  always_comb begin
    wr_en   = (cmd.do_add && !full) || cmd.do_hit;
    wr_addr = count_r[IW-1:0];
    wr_data = '{id: req_id_r, dec: req_dec_r, cnt: '0};
    if (cmd.do_hit) begin
      wr_addr = chk_idx_r;
      wr_data = '{id: rd_data_r.id, dec: rd_data_r.dec,
                  cnt: (pass ? '0 : cnt_inc)};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_mem[wr_addr] <= wr_data;
    end
  end

  // Totals, entry count and result
  always_comb begin
    count_nxt   = count_r;
    sent_nxt    = sent_r;
    drop_nxt    = drop_r;
    cyc_nxt     = cyc_r;
    strobe_nxt  = 1'b0;
    verdict_nxt = verdict_r;
    if (cmd.do_add) begin
      strobe_nxt = 1'b1;
      if (full) begin
        verdict_nxt = V_FULL;
      end else begin
        count_nxt   = count_r + CW'(1);
        verdict_nxt = V_ADDED;
      end
    end else if (cmd.do_cycle) begin
      strobe_nxt  = 1'b1;
      cyc_nxt     = cyc_r + TOTAL_W'(1);
      verdict_nxt = V_CYCLE;
    end else if (cmd.do_hit) begin
      strobe_nxt = 1'b1;
      if (pass) begin
        sent_nxt    = sent_r + TOTAL_W'(1);
        verdict_nxt = V_SENT;
      end else begin
        drop_nxt    = drop_r + TOTAL_W'(1);
        verdict_nxt = V_DROPPED;
      end
    end else if (cmd.do_nomatch) begin
      strobe_nxt  = 1'b1;
      verdict_nxt = V_NOMATCH;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      sent_r   <= '0;
      drop_r   <= '0;
      cyc_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      sent_r   <= sent_nxt;
      drop_r   <= drop_nxt;
      cyc_r    <= cyc_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    verdict_r <= verdict_nxt;
  end

  // Drive result ports
  assign use_ext            = {{USE_W{1'b0}}, count_r};
  assign out_strobe         = strobe_r;
  assign out_verdict        = verdict_r;
  assign out_sent_total     = sent_r;
  assign out_dropped_total  = drop_r;
  assign out_cycle_total    = cyc_r;
  assign out_entries_in_use = use_ext[USE_W-1:0];

endmodule

`default_nettype wire

// ===== hdl/per_id_packet_decimation_filter_unit.sv =====
// ----------------------------------------------------------------------------
// per_id_packet_decimation_filter_unit
// Per-message-ID decimation filter: a table of IDs with decimation factors
// and running counters decides whether each packet is sent or dropped, and
// keeps sent, dropped and cycle totals.
//
//   Channel  Ports                                  Handshake
//   -------  -------------------------------------  -----------------------
//   request  in_action, in_msg_id, in_decimation    start high, busy low
//   result   out_verdict, out_*_total,              out_strobe, one cycle
//            out_entries_in_use
//   config   psel, penable, pwrite, paddr, pwdata,  APB write, pready = 1
//            prdata, pready
//
// Timing: busy rises on the edge that takes the request. An add, a
// command/wakeup packet or a packet against an empty table holds busy only
// in the decide state. A lookup reads one table entry per cycle: busy holds
// through the decide state and one scan state per entry read, up to the
// match or over all entries in use. The result strobe sits in the first
// cycle with busy low again, and start may be taken in that same cycle.
// Reset (rst_n low, synchronous) clears state, count, scan index, totals,
// strobe and ID registers, not the table. The receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module per_id_packet_decimation_filter_unit #(
  parameter int MAX_ENTRIES = pdf_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // Request
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        in_action,
  input  wire logic [pdf_pkg::ID_W-1:0]    in_msg_id,
  input  wire logic [pdf_pkg::DEC_W-1:0]   in_decimation,
  // Result
  output logic                             out_strobe,
  output logic [pdf_pkg::VERD_W-1:0]       out_verdict,
  output logic [pdf_pkg::TOTAL_W-1:0]      out_sent_total,
  output logic [pdf_pkg::TOTAL_W-1:0]      out_dropped_total,
  output logic [pdf_pkg::TOTAL_W-1:0]      out_cycle_total,
  output logic [pdf_pkg::USE_W-1:0]        out_entries_in_use,
  // Configuration
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [pdf_pkg::APB_AW-1:0]  paddr,
  input  wire logic [pdf_pkg::APB_DW-1:0]  pwdata,
  output logic      [pdf_pkg::APB_DW-1:0]  prdata,
  output logic                             pready
);
  import pdf_pkg::*;

  ctrl_cmd_t       cmd;
  dp_stat_t        stat;
  logic [ID_W-1:0] cmd_id;
  logic [ID_W-1:0] wake_id;

  // Configuration registers
  pdf_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cmd_id  (cmd_id),
    .wake_id (wake_id)
  );

  // Sequencer
  pdf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // Table, counters and result registers
  pdf_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_action          (in_action),
    .in_msg_id          (in_msg_id),
    .in_decimation      (in_decimation),
    .cmd_id             (cmd_id),
    .wake_id            (wake_id),
    .out_strobe         (out_strobe),
    .out_verdict        (out_verdict),
    .out_sent_total     (out_sent_total),
    .out_dropped_total  (out_dropped_total),
    .out_cycle_total    (out_cycle_total),
    .out_entries_in_use (out_entries_in_use)
  );

endmodule

`default_nettype wire
